/* rtl/ils_pkg.sv */
// Package for the indexed list store: operation and status codes, field widths,
// the per-cell control struct and the sequencer state type. No dependencies.
package ils_pkg;

  localparam int FUNC_W = 3;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  localparam int S_TDATA_W = 48;  // 42 bits of fields, padded to bytes
  localparam int M_TDATA_W = 48;  // 41 bits of fields, padded to bytes

  localparam logic [FUNC_W-1:0] FUNC_GET      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD_HEAD = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADD_TAIL = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ADD_AT   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DELETE   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic ins;  // open a slot at the position, load the new value
    logic del;  // close the slot at the position
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_FINAL = 3'b100
  } state_e;

endpackage

/* rtl/ils_cell.sv */
// One storage cell of the list chain: holds a single entry and shifts it to or
// from its neighbours on insert and delete. Depends on ils_pkg.
module ils_cell #(
  parameter int IDX = 0,
  parameter int PW  = 7,
  parameter int VW  = 32
) (
  input  logic               clk_i,
  input  ils_pkg::cell_ctrl_t ctrl_i,
  input  logic [PW-1:0]      pos_i,
  input  logic [VW-1:0]      new_i,
  input  logic [VW-1:0]      left_i,
  input  logic [VW-1:0]      right_i,
  output logic [VW-1:0]      val_o,
  output logic [VW-1:0]      hit_o
);
  import ils_pkg::*;

  logic [VW-1:0] val_q, val_d;
  logic          is_eq, is_gt;

  assign is_eq = (pos_i == PW'(IDX));
  assign is_gt = (PW'(IDX) > pos_i);

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (is_gt) val_d = left_i;
      else if (is_eq) val_d = new_i;
    end else if (ctrl_i.del) begin
      if (is_gt || is_eq) val_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign hit_o = is_eq ? val_q : '0;

endmodule

/* rtl/indexed_list_store.sv */
// Top level of the indexed list store: command sequencer, chain of cells,
// registered OR tree for reads and the result register. Depends on ils_pkg, ils_cell.
//
//  channel  | dir | payload (low bit up)                     | handshake
//  ---------+-----+------------------------------------------+----------------------
//  s_axis   | in  | func[2:0] position[9:3] item_value[41:10] | s_axis_tvalid/tready
//  m_axis   | out | read_value[31:0] status[33:32]            | m_axis_tvalid/tready
//           |     | count_now[40:34]                          |
//
// Each beat passes through the states idle (accept), execute (all cells shift at once and
// the read is gathered into groups of eight) and final (combine the groups into the result).
// A new beat is accepted only in the idle state, once the last result is registered;
// the combine step waits while an untaken result holds the output register.
// Reset clears the count and the handshake state; entries are not cleared.
module indexed_list_store #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ils_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // func, position, item_value
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ils_pkg::M_TDATA_W-1:0]  m_axis_tdata   // read_value, status, count_now
);
  import ils_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int NG = (CAPACITY + 7) / 8;
  localparam int VW = VALUE_WIDTH;

  state_e            state_q, state_d;
  logic [FUNC_W-1:0] func_q;
  logic [POS_W-1:0]  pos_q;
  logic [VW-1:0]     new_q;
  logic [CW-1:0]     count_q, count_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic              rd_ok_q, rd_ok_d;
  logic [VW-1:0]     grp_q [NG];
  logic [VW-1:0]     grp_d [NG];

  logic              out_valid_q;
  logic [DATA_W-1:0] out_rd_q;
  logic [STAT_W-1:0] out_stat_q;
  logic [CNT_W-1:0]  out_cnt_q;

  logic [63:0]       in_ext;
  logic [PW-1:0]     pos_w, cnt_w, ins_pos, cell_pos;
  logic              is_ins;
  cell_ctrl_t        ctrl;
  logic [VW-1:0]     cell_val [CAPACITY];
  logic [VW-1:0]     cell_hit [CAPACITY];
  logic [VW-1:0]     rd_all;
  logic [63:0]       rd_ext;
  logic              accept, final_go;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign final_go      = (state_q == ST_FINAL) && (!out_valid_q || m_axis_tready);

  assign in_ext = 64'(signed'(s_axis_tdata[41:10]));
  assign pos_w  = PW'(pos_q);
  assign cnt_w  = PW'(count_q);

  // operation decode and status
  always_comb begin
    is_ins  = 1'b0;
    ins_pos = pos_w;
    stat_d  = STAT_RANGE;
    count_d = count_q;
    rd_ok_d = 1'b0;
    ctrl    = '0;
    case (func_q)
      FUNC_GET: begin
        if (pos_w < cnt_w) begin
          stat_d  = STAT_DONE;
          rd_ok_d = 1'b1;
        end
      end
      FUNC_ADD_HEAD: begin
        is_ins  = 1'b1;
        ins_pos = '0;
      end
      FUNC_ADD_TAIL: begin
        is_ins  = 1'b1;
        ins_pos = cnt_w;
      end
      FUNC_ADD_AT: begin
        is_ins  = 1'b1;
      end
      FUNC_DELETE: begin
        if (pos_w < cnt_w) begin
          stat_d   = STAT_DONE;
          count_d  = count_q - CW'(1);
          ctrl.del = (state_q == ST_EXEC);
        end
      end
      default: ;
    endcase
    if (is_ins) begin
      if (ins_pos > cnt_w) stat_d = STAT_RANGE;
      else if (count_q >= CW'(CAPACITY)) stat_d = STAT_FULL;
      else begin
        stat_d   = STAT_DONE;
        count_d  = count_q + CW'(1);
        ctrl.ins = (state_q == ST_EXEC);
      end
    end
  end

  assign cell_pos = is_ins ? ins_pos : pos_w;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = new_q;
    end else begin : g_mid_l
      assign left = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_val[i];
    end else begin : g_mid_r
      assign right = cell_val[i+1];
    end
    ils_cell #(
      .IDX (i),
      .PW  (PW),
      .VW  (VW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (cell_pos),
      .new_i   (new_q),
      .left_i  (left),
      .right_i (right),
      .val_o   (cell_val[i]),
      .hit_o   (cell_hit[i])
    );
  end

  // first level of the read tree
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < 8; k++) begin
        if (g * 8 + k < CAPACITY) grp_d[g] = grp_d[g] | cell_hit[g*8+k];
      end
    end
  end

  always_comb begin
    rd_all = '0;
    for (int g = 0; g < NG; g++) rd_all = rd_all | grp_q[g];
  end

  assign rd_ext = 64'(signed'(rd_all));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_FINAL;
      ST_FINAL: if (final_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_EXEC) count_q <= count_d;
      if (final_go) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= s_axis_tdata[2:0];
      pos_q  <= s_axis_tdata[9:3];
      new_q  <= in_ext[VW-1:0];
    end
    if (state_q == ST_EXEC) begin
      stat_q  <= stat_d;
      rd_ok_q <= rd_ok_d;
      grp_q   <= grp_d;
    end
    if (final_go) begin
      out_rd_q   <= rd_ok_q ? rd_ext[DATA_W-1:0] : '1;
      out_stat_q <= stat_q;
      out_cnt_q  <= CNT_W'(count_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - DATA_W - STAT_W - CNT_W){1'b0}},
                          out_cnt_q, out_stat_q, out_rd_q};

endmodule
